/* src/positional_list_insert_remove_unit_assert.svh */
// Assertion helpers shared by the list unit.
// Each helper expects signals named clk and rst_n in the enclosing module.
`ifndef POSITIONAL_LIST_INSERT_REMOVE_UNIT_ASSERT_SVH
`define POSITIONAL_LIST_INSERT_REMOVE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PLIR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PLIR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/plir_pkg.sv */
package plir_pkg;

  // List geometry. The length and position fields are five bits wide,
  // enough to hold a length of up to the capacity.
  localparam int CAPACITY = 16;
  localparam int CNT_W    = 5;
  localparam int DATA_W   = 32;

  typedef logic signed [DATA_W-1:0] word_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [1:0]               mode_t;
  typedef logic [2:0]               status_t;
  typedef logic [1:0]               op_t;

  // Requested operation.
  localparam mode_t MODE_APPEND  = 2'd0;
  localparam mode_t MODE_INSERT  = 2'd1;
  localparam mode_t MODE_DEL_POS = 2'd2;
  localparam mode_t MODE_DEL_VAL = 2'd3;

  // Result status.
  localparam status_t ST_OK       = 3'd0;
  localparam status_t ST_RANGE    = 3'd1;
  localparam status_t ST_EMPTY    = 3'd2;
  localparam status_t ST_NOTFOUND = 3'd3;
  localparam status_t ST_FULL     = 3'd4;

  // Action applied to the cell row.
  localparam op_t OP_NONE    = 2'd0;
  localparam op_t OP_INS     = 2'd1;
  localparam op_t OP_DEL_POS = 2'd2;
  localparam op_t OP_DEL_VAL = 2'd3;

  localparam cnt_t CAP_CNT = CNT_W'(CAPACITY);

  // Control broadcast from the top level to every cell.
  typedef struct packed {
    op_t   op;
    cnt_t  at;
    word_t value;
    cnt_t  count;
  } ctrl_t;

endpackage

/* src/plir_if.sv */
// Request channel: operation, operand value and position.
interface plir_in_if;
  logic                 valid;
  logic                 ready;
  logic [1:0]           mode;
  logic signed [31:0]   value;
  logic [4:0]           position;

  modport source (output valid, output mode, output value, output position, input ready);
  modport sink   (input valid, input mode, input value, input position, output ready);
endinterface

// Result channel: status, removed entry and new length.
interface plir_out_if;
  logic                 valid;
  logic                 ready;
  logic [2:0]           status;
  logic signed [31:0]   removed_value;
  logic [4:0]           length;

  modport source (output valid, output status, output removed_value, output length,
                  input ready);
  modport sink   (input valid, input status, input removed_value, input length,
                  output ready);
endinterface

/* src/plir_cell.sv */
module plir_cell #(
  parameter int IDX = 0
) (
  input  logic            clk,
  input  plir_pkg::ctrl_t ctrl,
  input  plir_pkg::word_t left_i,
  input  plir_pkg::word_t right_i,
  output plir_pkg::word_t entry_o,
  input  logic            found_i,
  output logic            found_o,
  input  plir_pkg::word_t take_i,
  output plir_pkg::word_t take_o
);
  import plir_pkg::*;

  localparam cnt_t IDX_C = CNT_W'(IDX);

  word_t entry_r;
  word_t entry_nxt;
  logic  live;
  logic  match;

  // A cell holds a list entry only below the current length.
  assign live    = IDX_C < ctrl.count;
  assign match   = live && (entry_r == ctrl.value);
  assign found_o = found_i | match;

  // The entry at the requested position travels down the take chain.
  assign take_o  = (IDX_C == ctrl.at) ? entry_r : take_i;
  assign entry_o = entry_r;

  // Insert shifts up from the left neighbor, removal shifts down from the right.
  always_comb begin
    entry_nxt = entry_r;
    case (ctrl.op)
      OP_INS: begin
        if (IDX_C == ctrl.at) begin
          entry_nxt = ctrl.value;
        end else if (IDX_C > ctrl.at) begin
          entry_nxt = left_i;
        end
      end
      OP_DEL_POS: begin
        if (IDX_C >= ctrl.at) begin
          entry_nxt = right_i;
        end
      end
      OP_DEL_VAL: begin
        if (found_o) begin
          entry_nxt = right_i;
        end
      end
      default: entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

/* src/positional_list_insert_remove_unit.sv */
// Bounded ordered list of signed 32-bit values, up to 16 entries.
// Request words on in_chan carry a mode (append, insert at position,
// remove at position, remove first entry equal to value), a value and a
// position. Each request yields exactly one result word on out_chan with
// a status, the removed value (zero unless a removal succeeded) and the
// new length.
// The result is registered and is valid in the cycle after request
// acceptance; a new request is taken every cycle while the result
// register is empty or is being drained. The whole operation resolves in
// a single pass across the row of entry cells; the longest path is the
// first-match chain through all 16 cells on a remove by value.
// When the receiver stalls, the result is held in the output register and
// in_chan.ready drops until it is taken; no request is lost.
// Reset (rst_n low, synchronous) empties the list and clears the result
// valid. Entry contents are not reset; only positions below the length
// are ever read.
module positional_list_insert_remove_unit (
  input  logic        clk,
  input  logic        rst_n,
  plir_in_if.sink     in_chan,
  plir_out_if.source  out_chan
);
  import plir_pkg::*;

  `include "positional_list_insert_remove_unit_assert.svh"

  cnt_t    count_r;
  cnt_t    count_nxt;
  logic    out_valid_r;
  status_t status_r;
  word_t   removed_r;
  cnt_t    length_r;

  status_t status_nxt;
  word_t   removed_nxt;
  op_t     op_sel;
  cnt_t    at_sel;
  logic    in_acc;
  ctrl_t   ctrl;

  word_t   entry_w [CAPACITY];
  logic    found_w [CAPACITY+1];
  word_t   take_w  [CAPACITY+1];

  // A request is taken whenever the result register is free or draining.
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_acc        = in_chan.valid && in_chan.ready;

  // Decode the request into a status and a row action.
  always_comb begin
    status_nxt  = ST_OK;
    removed_nxt = '0;
    op_sel      = OP_NONE;
    at_sel      = in_chan.position;
    count_nxt   = count_r;
    case (in_chan.mode)
      MODE_APPEND: begin
        at_sel = count_r;
        if (count_r >= CAP_CNT) begin
          status_nxt = ST_FULL;
        end else begin
          op_sel    = OP_INS;
          count_nxt = count_r + 1'b1;
        end
      end
      MODE_INSERT: begin
        if (in_chan.position > count_r) begin
          status_nxt = ST_RANGE;
        end else if (count_r >= CAP_CNT) begin
          status_nxt = ST_FULL;
        end else begin
          op_sel    = OP_INS;
          count_nxt = count_r + 1'b1;
        end
      end
      MODE_DEL_POS: begin
        if (in_chan.position >= count_r) begin
          status_nxt = ST_RANGE;
        end else begin
          op_sel      = OP_DEL_POS;
          removed_nxt = take_w[CAPACITY];
          count_nxt   = count_r - 1'b1;
        end
      end
      MODE_DEL_VAL: begin
        if (count_r == '0) begin
          status_nxt = ST_EMPTY;
        end else if (!found_w[CAPACITY]) begin
          status_nxt = ST_NOTFOUND;
        end else begin
          op_sel      = OP_DEL_VAL;
          removed_nxt = in_chan.value;
          count_nxt   = count_r - 1'b1;
        end
      end
      default: status_nxt = ST_OK;
    endcase
  end

  // The row only changes on an accepted request.
  assign ctrl.op    = in_acc ? op_sel : OP_NONE;
  assign ctrl.at    = at_sel;
  assign ctrl.value = in_chan.value;
  assign ctrl.count = count_r;

  // Row of entry cells with shift, first-match and take chains.
  assign found_w[0] = 1'b0;
  assign take_w[0]  = '0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    word_t left_v;
    word_t right_v;

    if (g == 0) begin : g_first
      assign left_v = in_chan.value;
    end else begin : g_mid_l
      assign left_v = entry_w[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right_v = entry_w[g];
    end else begin : g_mid_r
      assign right_v = entry_w[g+1];
    end

    plir_cell #(.IDX(g)) u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .left_i  (left_v),
      .right_i (right_v),
      .entry_o (entry_w[g]),
      .found_i (found_w[g]),
      .found_o (found_w[g+1]),
      .take_i  (take_w[g]),
      .take_o  (take_w[g+1])
    );
  end

  // Length and result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      status_r  <= status_nxt;
      removed_r <= removed_nxt;
      length_r  <= count_nxt;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.status        = status_r;
  assign out_chan.removed_value = removed_r;
  assign out_chan.length        = length_r;

  `PLIR_ASSERT_SAME(a_len_bound, 1'b1, count_r <= CAP_CNT, "length beyond capacity")
  `PLIR_ASSERT_NEXT(a_ins_grows, in_acc && status_nxt == ST_OK && (in_chan.mode == MODE_APPEND || in_chan.mode == MODE_INSERT), count_r == $past(count_r) + 1'b1, "insert did not grow list")
  `PLIR_ASSERT_SAME(a_fail_zero, out_valid_r && status_r != ST_OK, removed_r == '0, "failed result carries a value")
  `PLIR_ASSERT_SAME(a_empty_mode, in_acc && (status_nxt == ST_EMPTY || status_nxt == ST_NOTFOUND), in_chan.mode == MODE_DEL_VAL, "search status on non-search mode")

endmodule

/* bench/positional_list_insert_remove_unit_tb.sv */
module positional_list_insert_remove_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import plir_pkg::*;

  localparam int N_RANDOM       = 1525;
  localparam int QUIET_TAIL     = 150;
  localparam int HOLD_AT        = 300;
  localparam int HOLD_CYCLES    = 80;
  localparam int WATCHDOG_LIMIT = 1000;

  // One expected result word.
  typedef struct {
    status_t status;
    word_t   removed;
    cnt_t    length;
  } list_result_t;

  // Mirror of the list contents and the queue of results still owed.
  class list_scoreboard;
    word_t        entries[CAPACITY];
    int unsigned  count;
    list_result_t owed[$];
    int           errors;

    function new();
      count  = 0;
      errors = 0;
    endfunction

    function int pending();
      return owed.size();
    endfunction

    // Removes the entry at the given index and closes the gap behind it.
    function word_t take_at(int unsigned at);
      word_t taken;
      taken = entries[at];
      for (int unsigned i = at; i + 1 < count; i++) entries[i] = entries[i + 1];
      count--;
      return taken;
    endfunction

    // Applies an accepted request word and records the result it must produce.
    function void note_request(mode_t mode, word_t value, cnt_t position);
      list_result_t r;
      int           hit;
      r.status  = ST_OK;
      r.removed = '0;
      hit       = -1;
      case (mode)
        MODE_APPEND: begin
          if (count >= CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            entries[count] = value;
            count++;
          end
        end
        MODE_INSERT: begin
          // The range check comes before the full check.
          if (position > count) begin
            r.status = ST_RANGE;
          end else if (count >= CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            for (int unsigned i = count; i > position; i--) entries[i] = entries[i - 1];
            entries[position] = value;
            count++;
          end
        end
        MODE_DEL_POS: begin
          if (position >= count) r.status = ST_RANGE;
          else r.removed = take_at(position);
        end
        default: begin
          if (count == 0) begin
            r.status = ST_EMPTY;
          end else begin
            for (int i = 0; i < int'(count) && hit < 0; i++) begin
              if (entries[i] == value) hit = i;
            end
            if (hit < 0) r.status = ST_NOTFOUND;
            else r.removed = take_at(hit);
          end
        end
      endcase
      r.length = cnt_t'(count);
      owed.push_back(r);
    endfunction

    // Compares a result word with the oldest expectation.
    function void check_result(status_t status, word_t removed, cnt_t length);
      list_result_t r;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result word: status %0d removed %0d length %0d",
                 $time, status, removed, length);
        errors++;
        return;
      end
      r = owed.pop_front();
      if (status !== r.status) begin
        $display("%0t: status mismatch: expected %0d actual %0d", $time, r.status, status);
        errors++;
      end
      if (removed !== r.removed) begin
        $display("%0t: removed_value mismatch: expected %0d actual %0d",
                 $time, r.removed, removed);
        errors++;
      end
      if (length !== r.length) begin
        $display("%0t: length mismatch: expected %0d actual %0d", $time, r.length, length);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  plir_in_if  in_chan();
  plir_out_if out_chan();

  positional_list_insert_remove_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  list_scoreboard sb = new();
  bit quiet        = 1'b0;
  bit hold_off_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Offers one request word, waits for it to be taken, then maybe idles.
  task automatic send_word(mode_t m, word_t v, cnt_t p);
    in_chan.valid    <= 1'b1;
    in_chan.mode     <= m;
    in_chan.value    <= v;
    in_chan.position <= p;
    do @(posedge clk); while (!in_chan.ready);
    sb.note_request(m, v, p);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // Values lean on current entries and corner values so removals by value hit.
  function automatic word_t pick_value();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 3 && sb.count != 0) return sb.entries[$urandom_range(0, sb.count - 1)];
    if (sel < 5) begin
      case ($urandom_range(0, 4))
        0:       return 32'sd0;
        1:       return -32'sd1;
        2:       return 32'sd1;
        3:       return 32'sh8000_0000;
        default: return 32'sh7fff_ffff;
      endcase
    end
    return word_t'($urandom);
  endfunction

  // One receiver cycle: drive ready, then check any result taken at the edge.
  task automatic rx_cycle(bit r);
    out_chan.ready <= r;
    @(posedge clk);
    if (rst_n && out_chan.valid && out_chan.ready)
      sb.check_result(out_chan.status, out_chan.removed_value, out_chan.length);
  endtask

  // Receiver with random stall bursts and one long hold-off.
  initial begin
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        repeat (HOLD_CYCLES) rx_cycle(1'b0);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 10)) rx_cycle(1'b0);
      end else begin
        rx_cycle(1'b1);
      end
    end
  end

  // Watchdog: ends the run when nothing moves on either channel for too long.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Reset, directed words, random words, then drain and report.
  initial begin
    int unsigned r;
    mode_t       m;
    cnt_t        p;
    bit          grow;
    grow             = 1'b1;
    rst_n            <= 1'b0;
    in_chan.valid    <= 1'b0;
    in_chan.mode     <= MODE_APPEND;
    in_chan.value    <= '0;
    in_chan.position <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Operations on an empty list.
    send_word(MODE_DEL_VAL, 32'sd0, 5'd0);
    send_word(MODE_DEL_POS, 32'sd0, 5'd0);
    send_word(MODE_INSERT, 32'sd9, 5'd1);
    // Extreme values, insert in the middle, a missed key, removal of the last entry.
    send_word(MODE_INSERT, 32'sh8000_0000, 5'd0);
    send_word(MODE_APPEND, 32'sh7fff_ffff, 5'd0);
    send_word(MODE_APPEND, -32'sd1, 5'd31);
    send_word(MODE_APPEND, 32'sd0, 5'd0);
    send_word(MODE_INSERT, 32'sd5, 5'd2);
    send_word(MODE_DEL_VAL, 32'sd12345, 5'd0);
    send_word(MODE_DEL_POS, 32'sd0, 5'd4);
    send_word(MODE_APPEND, 32'sd0, 5'd0);
    // Fill up with inserts at scattered positions, with a duplicate key.
    while (sb.count < CAPACITY) begin
      send_word(MODE_INSERT, (sb.count == 8) ? 32'sd5 : pick_value(),
                cnt_t'($urandom_range(0, sb.count)));
    end
    // Full list: full and out-of-range cases, then removals.
    send_word(MODE_APPEND, 32'sd1, 5'd0);
    send_word(MODE_INSERT, 32'sd1, 5'd16);
    send_word(MODE_INSERT, 32'sd1, 5'd17);
    send_word(MODE_INSERT, 32'sd1, 5'd31);
    send_word(MODE_DEL_POS, 32'sd0, 5'd16);
    send_word(MODE_DEL_POS, 32'sd0, 5'd15);
    send_word(MODE_DEL_VAL, 32'sd5, 5'd0);
    send_word(MODE_DEL_POS, 32'sd0, 5'd0);

    // Random words; the growth bias flips now and then so the length sweeps
    // its whole range.
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 64 == 0) grow = 1'($urandom_range(0, 1));
      if (n == HOLD_AT) hold_off_req = 1'b1;
      if (n == N_RANDOM - QUIET_TAIL) quiet = 1'b1;
      r = $urandom_range(0, 99);
      if (grow)
        m = (r < 35) ? MODE_APPEND : (r < 70) ? MODE_INSERT :
            (r < 85) ? MODE_DEL_POS : MODE_DEL_VAL;
      else
        m = (r < 15) ? MODE_APPEND : (r < 30) ? MODE_INSERT :
            (r < 65) ? MODE_DEL_POS : MODE_DEL_VAL;
      if ($urandom_range(0, 4) == 0)
        p = cnt_t'($urandom_range(0, 31));
      else if (m == MODE_INSERT)
        p = cnt_t'($urandom_range(0, sb.count));
      else
        p = (sb.count != 0) ? cnt_t'($urandom_range(0, sb.count - 1)) : '0;
      send_word(m, pick_value(), p);
    end
    in_chan.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
